// ===== hw/rtl/mosl_pkg.sv =====
package mosl_pkg;

    localparam int BODY_W      = 32;
    localparam int FILT_W      = 32;
    localparam int OWNER_IDX_W = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_SUPPRESS_MASK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVALID_BODY  = 1'd1;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [BODY_W-1:0] INVALID_BODY_RESET = 32'h7FFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH,
        ST_APPLY
    } mosl_state_t;

    typedef struct packed {
        logic                   command;
        logic [BODY_W-1:0]      body_id;
        logic [OWNER_IDX_W-1:0] owner_index;
        logic [FILT_W-1:0]      current_filter;
    } mosl_req_t;

    // first member sits in the top bits, so ok lands in bit 0
    typedef struct packed {
        logic              table_full;
        logic [1:0]        lease_count;
        logic              was_suppressed_before;
        logic              fully_released;
        logic              already_held;
        logic              first_lease;
        logic              changed;
        logic [FILT_W-1:0] new_filter;
        logic              ok;
    } mosl_res_t;

    localparam int RES_W = $bits(mosl_res_t);

    typedef struct packed {
        logic wr_en;
        logic wr_all;
        logic clr_used;
    } mosl_wr_t;

endpackage

// ===== hw/rtl/mosl_table.sv =====
module mosl_table
    import mosl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int OWNER_COUNT   = 3,
    parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mosl_wr_t                 wr_ctl,
    input  logic [IDX_W-1:0]         wr_addr,
    input  logic [BODY_W-1:0]        wr_body,
    input  logic [FILT_W-1:0]        wr_filter,
    input  logic                     wr_was,
    input  logic [OWNER_COUNT-1:0]   wr_owners,
    input  logic [IDX_W-1:0]         rd_addr,
    output logic [BODY_W-1:0]        rd_body,
    output logic [FILT_W-1:0]        rd_filter,
    output logic                     rd_was,
    output logic [OWNER_COUNT-1:0]   rd_owners,
    output logic [TABLE_ENTRIES-1:0] used
);

    logic [BODY_W-1:0]      body_mem   [TABLE_ENTRIES];
    logic [FILT_W-1:0]      filter_mem [TABLE_ENTRIES];
    logic                   was_mem    [TABLE_ENTRIES];
    logic [OWNER_COUNT-1:0] owners_mem [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] used_reg;
    logic [TABLE_ENTRIES-1:0] used_next;
    logic [BODY_W-1:0]        rd_body_reg;
    logic [FILT_W-1:0]        rd_filter_reg;
    logic                     rd_was_reg;
    logic [OWNER_COUNT-1:0]   rd_owners_reg;

    always_comb begin
        used_next = used_reg;
        if (wr_ctl.wr_en && wr_ctl.wr_all) begin
            used_next[wr_addr] = 1'b1;
        end
        if (wr_ctl.clr_used) begin
            used_next[wr_addr] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_ctl.wr_en) begin
            owners_mem[wr_addr] <= wr_owners;
            if (wr_ctl.wr_all) begin
                body_mem[wr_addr]   <= wr_body;
                filter_mem[wr_addr] <= wr_filter;
                was_mem[wr_addr]    <= wr_was;
            end
        end
        rd_body_reg   <= body_mem[rd_addr];
        rd_filter_reg <= filter_mem[rd_addr];
        rd_was_reg    <= was_mem[rd_addr];
        rd_owners_reg <= owners_mem[rd_addr];
    end

    assign rd_body   = rd_body_reg;
    assign rd_filter = rd_filter_reg;
    assign rd_was    = rd_was_reg;
    assign rd_owners = rd_owners_reg;
    assign used      = used_reg;

endmodule

// ===== hw/rtl/mosl_ctrl.sv =====
module mosl_ctrl
    import mosl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int OWNER_COUNT   = 3,
    parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  mosl_req_t                req,
    input  logic [FILT_W-1:0]        suppress_mask,
    input  logic [BODY_W-1:0]        invalid_body,
    output logic                     m_valid,
    input  logic                     m_ready,
    output mosl_res_t                res,
    output mosl_wr_t                 wr_ctl,
    output logic [IDX_W-1:0]         wr_addr,
    output logic [BODY_W-1:0]        wr_body,
    output logic [FILT_W-1:0]        wr_filter,
    output logic                     wr_was,
    output logic [OWNER_COUNT-1:0]   wr_owners,
    output logic [IDX_W-1:0]         rd_addr,
    input  logic [BODY_W-1:0]        rd_body,
    input  logic [FILT_W-1:0]        rd_filter,
    input  logic                     rd_was,
    input  logic [OWNER_COUNT-1:0]   rd_owners,
    input  logic [TABLE_ENTRIES-1:0] used
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    mosl_state_t state_reg, state_next;
    mosl_req_t   req_reg, req_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             free_reg, free_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             inval_reg, inval_next;
    logic             m_valid_reg, m_valid_next;
    mosl_res_t        res_reg, res_next;

    logic [BODY_W-1:0]      cmp_b;
    logic                   cmp_eq;
    logic [FILT_W-1:0]      supp;
    logic                   owner_ok;
    logic [OWNER_COUNT-1:0] owner_bit;
    logic [OWNER_COUNT-1:0] new_owners;
    logic                   new_was;
    logic                   apply_all;
    logic                   apply_own;
    logic                   apply_clr;
    mosl_res_t              apply_res;

    function automatic logic [1:0] lease_total(input logic [OWNER_COUNT-1:0] m);
        logic [3:0] n;
        n = '0;
        for (int b = 0; b < OWNER_COUNT; b++) begin
            n = n + 4'(m[b]);
        end
        return (n > 4'd3) ? 2'd3 : n[1:0];
    endfunction

    // shared comparator: table body during the scan, invalid id while fetching
    assign cmp_b  = (state_reg == ST_FETCH) ? invalid_body : rd_body;
    assign cmp_eq = (req_reg.body_id == cmp_b);

    always_comb begin
        supp      = req_reg.current_filter | suppress_mask;
        owner_ok  = (32'(req_reg.owner_index) < OWNER_COUNT);
        owner_bit = owner_ok ? (OWNER_COUNT'(1) << req_reg.owner_index) : '0;
        new_owners = rd_owners;
        new_was   = |(req_reg.current_filter & suppress_mask);
        apply_all = 1'b0;
        apply_own = 1'b0;
        apply_clr = 1'b0;
        apply_res = '0;
        apply_res.new_filter = req_reg.current_filter;
        if (req_reg.command == CMD_ACQUIRE) begin
            apply_res.new_filter = supp;
            if (owner_ok && !inval_reg) begin
                if (!hit_reg) begin
                    if (!free_reg) begin
                        apply_res.table_full = 1'b1;
                        apply_res.new_filter = req_reg.current_filter;
                    end else begin
                        apply_all  = 1'b1;
                        new_owners = owner_bit;
                        apply_res.ok                    = 1'b1;
                        apply_res.first_lease           = 1'b1;
                        apply_res.was_suppressed_before = new_was;
                        apply_res.lease_count           = lease_total(owner_bit);
                    end
                end else if (|(rd_owners & owner_bit)) begin
                    apply_res.ok                    = 1'b1;
                    apply_res.already_held          = 1'b1;
                    apply_res.new_filter            = req_reg.current_filter;
                    apply_res.was_suppressed_before = rd_was;
                    apply_res.lease_count           = lease_total(rd_owners);
                end else begin
                    apply_own  = 1'b1;
                    new_owners = rd_owners | owner_bit;
                    apply_res.ok                    = 1'b1;
                    apply_res.was_suppressed_before = rd_was;
                    apply_res.lease_count           = lease_total(rd_owners | owner_bit);
                end
            end
        end else if (owner_ok && hit_reg) begin
            new_owners = rd_owners & ~owner_bit;
            apply_res.ok                    = 1'b1;
            apply_res.was_suppressed_before = rd_was;
            apply_res.lease_count           = lease_total(new_owners);
            if (new_owners != '0) begin
                apply_own = 1'b1;
                apply_res.new_filter = supp;
            end else begin
                apply_clr = 1'b1;
                apply_res.fully_released = 1'b1;
                apply_res.new_filter     = rd_filter;
            end
        end
        apply_res.changed = (apply_res.new_filter != req_reg.current_filter);
    end

    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        scan_idx_next = scan_idx_reg;
        cmp_idx_next  = cmp_idx_reg;
        cmp_vld_next  = cmp_vld_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        inval_next    = inval_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        rd_addr       = hit_idx_reg;
        wr_ctl        = '0;

        if (cmp_vld_reg && !hit_reg && used[cmp_idx_reg] && cmp_eq) begin
            hit_next     = 1'b1;
            hit_idx_next = cmp_idx_reg;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next      = req;
                    scan_idx_next = '0;
                    cmp_vld_next  = 1'b0;
                    hit_next      = 1'b0;
                    free_next     = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                rd_addr      = scan_idx_reg;
                cmp_vld_next = 1'b1;
                cmp_idx_next = scan_idx_reg;
                if (!free_reg && !used[scan_idx_reg]) begin
                    free_next     = 1'b1;
                    free_idx_next = scan_idx_reg;
                end
                if (scan_idx_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                cmp_vld_next = 1'b0;
                state_next   = ST_FETCH;
            end
            ST_FETCH: begin
                inval_next = cmp_eq;
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (!m_valid_reg || m_ready) begin
                    wr_ctl.wr_en    = apply_all || apply_own;
                    wr_ctl.wr_all   = apply_all;
                    wr_ctl.clr_used = apply_clr;
                    res_next        = apply_res;
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cmp_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            hit_reg     <= hit_next;
            free_reg    <= free_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        inval_reg    <= inval_next;
        res_reg      <= res_next;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign res       = res_reg;
    assign wr_addr   = hit_reg ? hit_idx_reg : free_idx_reg;
    assign wr_body   = req_reg.body_id;
    assign wr_filter = req_reg.current_filter;
    assign wr_was    = new_was;
    assign wr_owners = new_owners;

endmodule

// ===== hw/rtl/multi_owner_suppression_lease_table.sv =====
// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+--------------------------------------------
// s_      | in        | s_tvalid/s_tready  | tuser command; tdata body, owner, filter
// m_      | out       | m_tvalid/m_tready  | tdata result flags, new filter, lease count
// cfg_    | in        | cfg_we             | cfg_addr register index, cfg_wdata value
//
// A request passes from acceptance to m_tvalid through the scan, which reads one
// entry a cycle through the single table read port into one shared 32-bit comparator,
// then drain, fetch of the matched entry and apply, which waits until the output register
// is free. s_tready is high only while idle, so the next request waits for this one's apply;
// a result held in the output register does not block the next request until its apply step.
// Reset is synchronous on aresetn low and clears all valid bits.
module multi_owner_suppression_lease_table
    import mosl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int OWNER_COUNT   = 3
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // body_id[31:0], owner_index[33:32], current_filter[65:34], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // command[0]
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // ok[0], new_filter[32:1], changed[33], first_lease[34], already_held[35],
    // fully_released[36], was_suppressed_before[37], lease_count[39:38],
    // table_full[40], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [FILT_W-1:0] suppress_mask_reg;
    logic [BODY_W-1:0] invalid_body_reg;

    mosl_req_t req;
    mosl_res_t res;
    mosl_wr_t  wr_ctl;

    logic [IDX_W-1:0]         wr_addr;
    logic [BODY_W-1:0]        wr_body;
    logic [FILT_W-1:0]        wr_filter;
    logic                     wr_was;
    logic [OWNER_COUNT-1:0]   wr_owners;
    logic [IDX_W-1:0]         rd_addr;
    logic [BODY_W-1:0]        rd_body;
    logic [FILT_W-1:0]        rd_filter;
    logic                     rd_was;
    logic [OWNER_COUNT-1:0]   rd_owners;
    logic [TABLE_ENTRIES-1:0] used;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            suppress_mask_reg <= '0;
            invalid_body_reg  <= INVALID_BODY_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_SUPPRESS_MASK: suppress_mask_reg <= cfg_wdata[FILT_W-1:0];
                CFG_INVALID_BODY:  invalid_body_reg  <= cfg_wdata[BODY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign req.command        = s_tuser;
    assign req.body_id        = s_tdata[BODY_W-1:0];
    assign req.owner_index    = s_tdata[BODY_W+OWNER_IDX_W-1:BODY_W];
    assign req.current_filter = s_tdata[BODY_W+OWNER_IDX_W+FILT_W-1:BODY_W+OWNER_IDX_W];

    assign m_tdata = {{(OUT_TDATA_W-RES_W){1'b0}}, res};

    mosl_ctrl #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .OWNER_COUNT  (OWNER_COUNT),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .req          (req),
        .suppress_mask(suppress_mask_reg),
        .invalid_body (invalid_body_reg),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .res          (res),
        .wr_ctl       (wr_ctl),
        .wr_addr      (wr_addr),
        .wr_body      (wr_body),
        .wr_filter    (wr_filter),
        .wr_was       (wr_was),
        .wr_owners    (wr_owners),
        .rd_addr      (rd_addr),
        .rd_body      (rd_body),
        .rd_filter    (rd_filter),
        .rd_was       (rd_was),
        .rd_owners    (rd_owners),
        .used         (used)
    );

    mosl_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .OWNER_COUNT  (OWNER_COUNT),
        .IDX_W        (IDX_W)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_ctl   (wr_ctl),
        .wr_addr  (wr_addr),
        .wr_body  (wr_body),
        .wr_filter(wr_filter),
        .wr_was   (wr_was),
        .wr_owners(wr_owners),
        .rd_addr  (rd_addr),
        .rd_body  (rd_body),
        .rd_filter(rd_filter),
        .rd_was   (rd_was),
        .rd_owners(rd_owners),
        .used     (used)
    );

endmodule

// ===== hw/rtl/mosl_chk.sv =====
module mosl_chk
    import mosl_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    mosl_res_t r;

    assign r = mosl_res_t'(m_tdata[RES_W-1:0]);

    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while a request was in flight");

    a_refused_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !r.ok |-> r.lease_count == 2'd0 && !r.was_suppressed_before
            && !r.first_lease && !r.already_held && !r.fully_released)
        else $error("refused request reports entry state");

    a_full_unchanged: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.table_full |-> !r.ok && !r.changed)
        else $error("full table result applied or changed filter");

    a_release_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.fully_released |-> r.ok && r.lease_count == 2'd0)
        else $error("freed entry still reports owners");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result dropped or changed");

endmodule

bind multi_owner_suppression_lease_table mosl_chk u_mosl_chk (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import mosl_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int OWNERS      = 3;
    localparam int STALL_LIMIT = 2000;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    logic [FILT_W-1:0] suppress_bits = '0;
    logic [BODY_W-1:0] invalid_id    = INVALID_BODY_RESET;

    logic              lease_used     [ENTRIES];
    logic [BODY_W-1:0] lease_body     [ENTRIES];
    logic [FILT_W-1:0] lease_saved    [ENTRIES];
    logic              lease_was_supp [ENTRIES];
    logic [2:0]        lease_owners   [ENTRIES];

    mosl_res_t expected_leases[$];
    int        fail_count    = 0;
    int        idle_cycles   = 0;
    bit        sender_no_gap = 1'b0;
    bit        sink_no_stall = 1'b0;

    multi_owner_suppression_lease_table #(
        .TABLE_ENTRIES(ENTRIES),
        .OWNER_COUNT  (OWNERS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int find_lease(input logic [BODY_W-1:0] body);
        for (int i = 0; i < ENTRIES; i++) begin
            if (lease_used[i] && lease_body[i] == body) return i;
        end
        return -1;
    endfunction

    function automatic mosl_res_t predict_lease(input logic cmd, input logic [BODY_W-1:0] body,
                                                input logic [1:0] owner,
                                                input logic [FILT_W-1:0] cur);
        mosl_res_t   r;
        logic [31:0] supp;
        logic        owner_ok;
        logic [2:0]  owner_bit;
        int          s;
        r         = '0;
        supp      = cur | suppress_bits;
        owner_ok  = owner < OWNERS;
        owner_bit = owner_ok ? 3'(1 << owner) : 3'b000;
        r.new_filter = cur;
        if (cmd == CMD_ACQUIRE) begin
            r.new_filter = supp;
            if (owner_ok && body != invalid_id) begin
                s = find_lease(body);
                if (s < 0) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (s < 0 && !lease_used[i]) s = i;
                    end
                    if (s < 0) begin
                        r.table_full = 1'b1;
                        r.new_filter = cur;
                    end else begin
                        lease_used[s]     = 1'b1;
                        lease_body[s]     = body;
                        lease_saved[s]    = cur;
                        lease_was_supp[s] = (cur & suppress_bits) != '0;
                        lease_owners[s]   = owner_bit;
                        r.first_lease     = 1'b1;
                    end
                end else if ((lease_owners[s] & owner_bit) != '0) begin
                    r.already_held = 1'b1;
                    r.new_filter   = cur;
                end else begin
                    lease_owners[s] = lease_owners[s] | owner_bit;
                end
                if (s >= 0) begin
                    r.ok                    = 1'b1;
                    r.was_suppressed_before = lease_was_supp[s];
                    r.lease_count           = 2'($countones(lease_owners[s]));
                end
            end
        end else begin
            s = owner_ok ? find_lease(body) : -1;
            if (s >= 0) begin
                lease_owners[s]         = lease_owners[s] & ~owner_bit;
                r.ok                    = 1'b1;
                r.was_suppressed_before = lease_was_supp[s];
                r.lease_count           = 2'($countones(lease_owners[s]));
                if (lease_owners[s] != '0) begin
                    r.new_filter = supp;
                end else begin
                    r.fully_released = 1'b1;
                    r.new_filter     = lease_saved[s];
                    lease_used[s]    = 1'b0;
                end
            end
        end
        r.changed = r.new_filter != cur;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_SUPPRESS_MASK) suppress_bits = value;
        else invalid_id = value;
    endtask

    task automatic send_request(input logic cmd, input logic [BODY_W-1:0] body,
                                input logic [1:0] owner, input logic [FILT_W-1:0] filt);
        int gap;
        gap = sender_no_gap ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(IN_TDATA_W - 66){1'b0}}, filt, owner, body};
        do @(posedge aclk); while (!s_tready);
        expected_leases = {expected_leases, predict_lease(cmd, body, owner, filt)};
    endtask

    // drop valid and wait out every pending result
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_leases.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic test_single_body();
        send_request(CMD_ACQUIRE, 32'hFFFF_FFFF, 2'd0, 32'h0000_0000);
        send_request(CMD_ACQUIRE, 32'hFFFF_FFFF, 2'd0, 32'h0000_0010);
        send_request(CMD_ACQUIRE, 32'hFFFF_FFFF, 2'd1, 32'h0000_0010);
        send_request(CMD_ACQUIRE, 32'hFFFF_FFFF, 2'd2, 32'hFFFF_FFFF);
        send_request(CMD_ACQUIRE, 32'hFFFF_FFFF, 2'd3, 32'h0000_0000);
        send_request(CMD_RELEASE, 32'hFFFF_FFFF, 2'd3, 32'h0000_0000);
        send_request(CMD_RELEASE, 32'hFFFF_FFFF, 2'd1, 32'h0000_0000);
        send_request(CMD_RELEASE, 32'hFFFF_FFFF, 2'd1, 32'h0000_0010);
        send_request(CMD_RELEASE, 32'hFFFF_FFFF, 2'd0, 32'h0000_0010);
        send_request(CMD_RELEASE, 32'hFFFF_FFFF, 2'd2, 32'hFFFF_FFFF);
        settle();
    endtask

    task automatic test_refusals();
        send_request(CMD_ACQUIRE, invalid_id, 2'd0, 32'h1234_0000);
        send_request(CMD_RELEASE, 32'h0000_0000, 2'd2, 32'h0000_00FF);
        settle();
    endtask

    task automatic test_table_full();
        for (int i = 0; i < ENTRIES; i++) begin
            send_request(CMD_ACQUIRE, 32'h100 + i, 2'(i % OWNERS), $urandom);
        end
        send_request(CMD_ACQUIRE, 32'h0000_ABCD, 2'd1, 32'h0F0F_0F0F);
        settle();
    endtask

    task automatic test_random_traffic(input int count, input logic [BODY_W-1:0] pool_base,
                                       input int acquire_pct);
        int                pick;
        logic              cmd;
        logic [BODY_W-1:0] body;
        logic [1:0]        owner;
        logic [FILT_W-1:0] filt;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) body = pool_base + $urandom_range(0, 23);
            else if (pick < 93) body = $urandom;
            else body = invalid_id;
            cmd   = ($urandom_range(0, 99) < acquire_pct) ? CMD_ACQUIRE : CMD_RELEASE;
            owner = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            case ($urandom_range(0, 2))
                0: filt = $urandom;
                1: filt = $urandom & ~suppress_bits;
                default: filt = $urandom | suppress_bits;
            endcase
            send_request(cmd, body, owner, filt);
        end
        settle();
    endtask

    initial begin
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = sink_no_stall ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        mosl_res_t got;
        mosl_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = mosl_res_t'(m_tdata[RES_W-1:0]);
            if (expected_leases.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[31:0], '0);
            end else begin
                want = expected_leases.pop_front();
                if (got.ok != want.ok) report_mismatch("ok", 32'(got.ok), 32'(want.ok));
                if (got.new_filter != want.new_filter)
                    report_mismatch("new_filter", got.new_filter, want.new_filter);
                if (got.changed != want.changed)
                    report_mismatch("changed", 32'(got.changed), 32'(want.changed));
                if (got.first_lease != want.first_lease)
                    report_mismatch("first_lease", 32'(got.first_lease),
                                    32'(want.first_lease));
                if (got.already_held != want.already_held)
                    report_mismatch("already_held", 32'(got.already_held),
                                    32'(want.already_held));
                if (got.fully_released != want.fully_released)
                    report_mismatch("fully_released", 32'(got.fully_released),
                                    32'(want.fully_released));
                if (got.was_suppressed_before != want.was_suppressed_before)
                    report_mismatch("was_suppressed_before", 32'(got.was_suppressed_before),
                                    32'(want.was_suppressed_before));
                if (got.lease_count != want.lease_count)
                    report_mismatch("lease_count", 32'(got.lease_count),
                                    32'(want.lease_count));
                if (got.table_full != want.table_full)
                    report_mismatch("table_full", 32'(got.table_full), 32'(want.table_full));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            lease_used[i]     = 1'b0;
            lease_body[i]     = '0;
            lease_saved[i]    = '0;
            lease_was_supp[i] = 1'b0;
            lease_owners[i]   = '0;
        end
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(CFG_SUPPRESS_MASK, 32'h0000_0010);
        test_single_body();
        test_refusals();
        test_table_full();

        test_random_traffic(260, 32'h100, 50);

        write_reg(CFG_SUPPRESS_MASK, 32'hFFFF_FFFF);
        write_reg(CFG_INVALID_BODY, 32'h0000_0000);
        sender_no_gap = 1'b1;
        test_random_traffic(250, 32'h0000_0000, 60);

        write_reg(CFG_SUPPRESS_MASK, 32'h0000_0000);
        write_reg(CFG_INVALID_BODY, 32'hFFFF_FFFF);
        sender_no_gap = 1'b0;
        sink_no_stall = 1'b1;
        test_random_traffic(250, 32'hFFFF_FFE8, 55);

        begin
            logic [BODY_W-1:0] base;
            base = $urandom;
            write_reg(CFG_SUPPRESS_MASK, $urandom);
            write_reg(CFG_INVALID_BODY, base + 5);
            sender_no_gap = 1'b1;
            test_random_traffic(250, base, 55);
        end

        write_reg(CFG_SUPPRESS_MASK, 32'(1) << $urandom_range(0, 31));
        write_reg(CFG_INVALID_BODY, $urandom);
        sender_no_gap = 1'b0;
        sink_no_stall = 1'b0;
        test_random_traffic(260, $urandom, 45);

        write_reg(CFG_SUPPRESS_MASK, $urandom);
        write_reg(CFG_INVALID_BODY, INVALID_BODY_RESET);
        test_random_traffic(250, 32'h7FFF_FFF0, 50);

        repeat (30) @(posedge aclk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
